// ===== hdl/mandelbrot_escape_time_pixel_macros.svh =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: assertion macros
// Short forms for the clocked, reset-gated properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define METP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define METP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/metp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: package
// Widths, register map, reset values, sequencer states and small helpers.
// ----------------------------------------------------------------------------
package metp_pkg;

  // Field widths
  localparam int COLUMN_BITS = 12;
  localparam int ROW_BITS    = 12;
  localparam int FRAC_BITS   = 28;
  localparam int WORD_W      = 32;            // Q4.28 word
  localparam int PROD_W      = 2 * WORD_W;    // full product
  localparam int SQ_W        = PROD_W - FRAC_BITS;
  localparam int ITER_W      = 16;
  localparam int STEP_W      = 29;
  localparam int CHAN_W      = 8;
  localparam int LANES       = 3;             // multipliers in the shared unit

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER    = 2'd0,
    REG_REAL_ORIGIN = 2'd1,
    REG_IMAG_ORIGIN = 2'd2,
    REG_PIXEL_STEP  = 2'd3
  } cfg_reg_e;

  localparam logic [ITER_W-1:0]        MAX_ITER_RST    = ITER_W'(1000);
  localparam logic signed [WORD_W-1:0] REAL_ORIGIN_RST = -32'sd536870912;
  localparam logic signed [WORD_W-1:0] IMAG_ORIGIN_RST = -32'sd301989888;
  localparam logic [STEP_W-1:0]        PIXEL_STEP_RST  = STEP_W'(559241);

  // Escape threshold: 4.0 in the squared-magnitude format
  localparam logic signed [SQ_W:0] ESCAPE_LIMIT = signed'((SQ_W+1)'(1) << (FRAC_BITS + 2));

  // Palette fixed point: Q0.16 values that may reach 1.0, so 17 bits
  localparam int Q_FRAC = 16;
  localparam int Q_W    = Q_FRAC + 1;
  localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << Q_FRAC;
  localparam logic [Q_W-1:0] T_MAX = Q_ONE - Q_W'(1);

  // Quotient bits of count * 2^16 / limit (for a nonzero limit the quotient never exceeds 2^16)
  localparam int DIV_STEPS = Q_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);
  localparam logic [STEP_CNT_W-1:0] DIV_LAST = STEP_CNT_W'(DIV_STEPS - 1);

  // Channel gains and final shifts
  localparam logic signed [WORD_W-1:0] RED_GAIN   = WORD_W'(9 * 255);
  localparam logic signed [WORD_W-1:0] GREEN_GAIN = WORD_W'(15 * 255);
  localparam logic signed [WORD_W-1:0] BLUE_GAIN  = WORD_W'(17 * 255);
  localparam int PAL_SHIFT  = 16;
  localparam int BLUE_SHIFT = 17;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_COORD,
    ST_SQ,
    ST_ACC,
    ST_DIVLD,
    ST_DIV,
    ST_PAL1,
    ST_PAL2,
    ST_PAL3,
    ST_PAL4,
    ST_DONE
  } state_e;

  // Clamp a wide signed value to the signed word range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-WORD_W:0] top;
    top = v[PROD_W-1:WORD_W-1];
    if ((&top) || !(|top)) begin
      return v[WORD_W-1:0];
    end else if (v[PROD_W-1]) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

  // Q0.16 product floored back to Q0.16
  function automatic logic [Q_W-1:0] q16(input logic signed [PROD_W-1:0] p);
    return p[Q_FRAC+Q_W-1:Q_FRAC];
  endfunction

  // Clamp a shifted channel value to 0..255
  function automatic logic [CHAN_W-1:0] sat_chan(input logic [PROD_W-1:0] v);
    return (|v[PROD_W-1:CHAN_W]) ? {CHAN_W{1'b1}} : v[CHAN_W-1:0];
  endfunction

endpackage

// ===== hdl/mandelbrot_escape_time_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel
// Maps a pixel to a point c, iterates z = z*z + c and colors the count.
// ----------------------------------------------------------------------------
// Usage:
//   A command (pixel_column_i, pixel_row_i) is taken at a clock edge with
//   start high and busy low. busy stays high until the result word is shown.
//   The result (iteration_count_o, red_o, green_o, blue_o) is valid for
//   exactly one cycle while done_o is high; the receiver cannot stall it and
//   must take it in that cycle. busy is already low in the done_o cycle, so a
//   new command may be issued there.
//   Each iteration uses the shared three-lane multiplier in ST_SQ and the
//   add/escape test in ST_ACC; the tail is a bit-serial divide for t and
//   four palette passes through the same multipliers. One pixel at a time.
//   Configuration (cfg_we_i, cfg_index_i, cfg_data_i) must be written only
//   while the block is idle; the block itself does not enforce this. A
//   write takes effect at the next command.
//   Reset clears the sequencer and loads the default window and limit.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel
  import metp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [COLUMN_BITS-1:0] pixel_column_i,
  input  logic [ROW_BITS-1:0]    pixel_row_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                   done_o,
  output logic [ITER_W-1:0]      iteration_count_o,
  output logic [CHAN_W-1:0]      red_o,
  output logic [CHAN_W-1:0]      green_o,
  output logic [CHAN_W-1:0]      blue_o
);

  // Configuration registers
  logic [ITER_W-1:0]        max_iter_q;
  logic signed [WORD_W-1:0] real_origin_q;
  logic signed [WORD_W-1:0] imag_origin_q;
  logic [STEP_W-1:0]        pixel_step_q;

  // Sequencer and loop control
  state_e                  state_q, state_d;
  logic [ITER_W-1:0]       count_q, count_d;
  logic [STEP_CNT_W-1:0]   step_q, step_d;
  logic                    done_q, done_d;

  // Datapath
  logic [COLUMN_BITS-1:0]   col_q, col_d;
  logic [ROW_BITS-1:0]      row_q, row_d;
  logic signed [WORD_W-1:0] cr_q, cr_d, ci_q, ci_d;
  logic signed [WORD_W-1:0] zr_q, zr_d, zi_q, zi_d;
  logic [ITER_W-1:0]        rem_q, rem_d;
  logic [Q_W-1:0]           dvd_q, dvd_d;
  logic [Q_W-1:0]           quot_q, quot_d;
  logic [Q_W-1:0]           t_q, t_d, u_q, u_d;
  logic [CHAN_W-1:0]        gsat_q, gsat_d;
  logic [CHAN_W-1:0]        red_q, red_d, green_q, green_d, blue_q, blue_d;

  // Shared multiplier lanes
  logic signed [WORD_W-1:0] mul_a [LANES];
  logic signed [WORD_W-1:0] mul_b [LANES];
  logic signed [PROD_W-1:0] prod_d [LANES];
  logic signed [PROD_W-1:0] prod_q [LANES];

  // Iteration arithmetic
  logic signed [SQ_W-1:0] rr_w, ii_w;
  logic signed [SQ_W:0]   ri_w, mag_w;
  logic signed [SQ_W+1:0] zr_sum_w, zi_sum_w;
  logic                   escape_w;

  // Divider step
  logic [ITER_W:0]   rem_sh_w;
  logic [ITER_W+1:0] diff_w;
  logic              qbit_w;

  // Palette inputs
  logic [Q_W-1:0] t_w, u_w;

  // --------------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q    <= MAX_ITER_RST;
      real_origin_q <= REAL_ORIGIN_RST;
      imag_origin_q <= IMAG_ORIGIN_RST;
      pixel_step_q  <= PIXEL_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MAX_ITER:    max_iter_q    <= cfg_data_i[ITER_W-1:0];
        REG_REAL_ORIGIN: real_origin_q <= signed'(cfg_data_i[WORD_W-1:0]);
        REG_IMAG_ORIGIN: imag_origin_q <= signed'(cfg_data_i[WORD_W-1:0]);
        REG_PIXEL_STEP:  pixel_step_q  <= cfg_data_i[STEP_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Shared unit operand select
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mul_a[i] = '0;
      mul_b[i] = '0;
    end
    unique case (state_q)
      ST_MAP: begin
        mul_a[0] = signed'(WORD_W'(col_q));
        mul_b[0] = signed'(WORD_W'(pixel_step_q));
        mul_a[1] = signed'(WORD_W'(row_q));
        mul_b[1] = signed'(WORD_W'(pixel_step_q));
      end
      ST_SQ: begin
        mul_a[0] = zr_q;
        mul_b[0] = zr_q;
        mul_a[1] = zi_q;
        mul_b[1] = zi_q;
        mul_a[2] = zr_q;
        mul_b[2] = zi_q;
      end
      ST_PAL1: begin  // t^2, u^2
        mul_a[0] = signed'(WORD_W'(t_w));
        mul_b[0] = signed'(WORD_W'(t_w));
        mul_a[1] = signed'(WORD_W'(u_w));
        mul_b[1] = signed'(WORD_W'(u_w));
      end
      ST_PAL2: begin  // t^3, u^3, u^2 t^2
        mul_a[0] = signed'(WORD_W'(q16(prod_q[0])));
        mul_b[0] = signed'(WORD_W'(t_q));
        mul_a[1] = signed'(WORD_W'(q16(prod_q[1])));
        mul_b[1] = signed'(WORD_W'(u_q));
        mul_a[2] = signed'(WORD_W'(q16(prod_q[1])));
        mul_b[2] = signed'(WORD_W'(q16(prod_q[0])));
      end
      ST_PAL3: begin  // t^3 u, u^3 t, green gain
        mul_a[0] = signed'(WORD_W'(q16(prod_q[0])));
        mul_b[0] = signed'(WORD_W'(u_q));
        mul_a[1] = signed'(WORD_W'(q16(prod_q[1])));
        mul_b[1] = signed'(WORD_W'(t_q));
        mul_a[2] = signed'(WORD_W'(q16(prod_q[2])));
        mul_b[2] = GREEN_GAIN;
      end
      ST_PAL4: begin  // red and blue gains
        mul_a[0] = signed'(WORD_W'(q16(prod_q[0])));
        mul_b[0] = RED_GAIN;
        mul_a[1] = signed'(WORD_W'(q16(prod_q[1])));
        mul_b[1] = BLUE_GAIN;
      end
      default: ;
    endcase
    for (int i = 0; i < LANES; i++) begin
      prod_d[i] = PROD_W'(mul_a[i]) * PROD_W'(mul_b[i]);
    end
  end

  // --------------------------------------------------------------------------
  // Escape test and next iterate from the registered products
  assign rr_w     = SQ_W'(prod_q[0] >>> FRAC_BITS);
  assign ii_w     = SQ_W'(prod_q[1] >>> FRAC_BITS);
  assign ri_w     = (SQ_W+1)'(prod_q[2] >>> (FRAC_BITS - 1));  // 2*zr*zi
  assign mag_w    = (SQ_W+1)'(rr_w) + (SQ_W+1)'(ii_w);
  assign escape_w = (mag_w >= ESCAPE_LIMIT);
  assign zr_sum_w = (SQ_W+2)'(rr_w) - (SQ_W+2)'(ii_w) + (SQ_W+2)'(cr_q);
  assign zi_sum_w = (SQ_W+2)'(ri_w) + (SQ_W+2)'(ci_q);

  // Restoring divide, one quotient bit per cycle
  assign rem_sh_w = {rem_q, dvd_q[Q_W-1]};
  assign diff_w   = {1'b0, rem_sh_w} - {2'b00, max_iter_q};
  assign qbit_w   = !diff_w[ITER_W+1];

  // t = count / limit in Q0.16, clamped below 1.0; zero limit gives t = 0
  assign t_w = (max_iter_q == '0) ? '0 : (quot_q[Q_W-1] ? T_MAX : quot_q);
  assign u_w = Q_ONE - t_w;

  // --------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) begin
                  state_d = ST_MAP;
                end
      ST_MAP:   state_d = ST_COORD;
      ST_COORD: state_d = ST_SQ;
      ST_SQ:    state_d = (count_q >= max_iter_q) ? ST_DIVLD : ST_ACC;
      ST_ACC:   state_d = escape_w ? ST_DIVLD : ST_SQ;
      ST_DIVLD: state_d = ST_DIV;
      ST_DIV:   if (step_q == DIV_LAST) begin
                  state_d = ST_PAL1;
                end
      ST_PAL1:  state_d = ST_PAL2;
      ST_PAL2:  state_d = ST_PAL3;
      ST_PAL3:  state_d = ST_PAL4;
      ST_PAL4:  state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and status updates
  always_comb begin
    count_d = count_q;
    step_d  = step_q;
    col_d   = col_q;
    row_d   = row_q;
    cr_d    = cr_q;
    ci_d    = ci_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    quot_d  = quot_q;
    t_d     = t_q;
    u_d     = u_q;
    gsat_d  = gsat_q;
    red_d   = red_q;
    green_d = green_q;
    blue_d  = blue_q;
    done_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          col_d = pixel_column_i;
          row_d = pixel_row_i;
        end
      end
      ST_COORD: begin
        cr_d    = sat_word(prod_q[0] + PROD_W'(real_origin_q));
        ci_d    = sat_word(prod_q[1] + PROD_W'(imag_origin_q));
        zr_d    = '0;
        zi_d    = '0;
        count_d = '0;
      end
      ST_ACC: begin
        if (!escape_w) begin
          zr_d    = sat_word(PROD_W'(zr_sum_w));
          zi_d    = sat_word(PROD_W'(zi_sum_w));
          count_d = count_q + ITER_W'(1);
        end
      end
      ST_DIVLD: begin
        // dividend is count * 2^16; its top bits seed the remainder
        rem_d  = count_q >> 1;
        dvd_d  = {count_q[0], {(Q_W-1){1'b0}}};
        quot_d = '0;
        step_d = '0;
      end
      ST_DIV: begin
        rem_d  = qbit_w ? diff_w[ITER_W-1:0] : rem_sh_w[ITER_W-1:0];
        dvd_d  = dvd_q << 1;
        quot_d = {quot_q[Q_W-2:0], qbit_w};
        step_d = step_q + STEP_CNT_W'(1);
      end
      ST_PAL1: begin
        t_d = t_w;
        u_d = u_w;
      end
      ST_PAL4: begin
        gsat_d = sat_chan(unsigned'(prod_q[2]) >> PAL_SHIFT);
      end
      ST_DONE: begin
        red_d   = sat_chan(unsigned'(prod_q[0]) >> PAL_SHIFT);
        blue_d  = sat_chan(unsigned'(prod_q[1]) >> BLUE_SHIFT);
        green_d = gsat_q;
        done_d  = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    row_q   <= row_d;
    cr_q    <= cr_d;
    ci_q    <= ci_d;
    zr_q    <= zr_d;
    zi_q    <= zi_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    quot_q  <= quot_d;
    t_q     <= t_d;
    u_q     <= u_d;
    gsat_q  <= gsat_d;
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
    for (int i = 0; i < LANES; i++) begin
      prod_q[i] <= prod_d[i];
    end
  end

  // Outputs
  assign busy              = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign iteration_count_o = count_q;
  assign red_o             = red_q;
  assign green_o           = green_q;
  assign blue_o            = blue_q;

endmodule

// ===== hdl/metp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: port checker
// Watches the command and result ports of the top level over time.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_macros.svh"

module metp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // Result word is a single-cycle strobe
  `METP_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "result strobe held")
  // Accepted command raises busy
  `METP_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy, "command not taken")
  // Result word only shows once the block is free again
  `METP_ASSERT_SAME(a_done_idle, clk_i, rst_ni, done_o, !busy, "result shown while busy")
  // Every finished command ends with a result word
  `METP_ASSERT_SAME(a_busy_fall, clk_i, rst_ni, $fell(busy), done_o, "busy fell, no result")

endmodule

bind mandelbrot_escape_time_pixel metp_checker u_metp_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: testbench
// Sends pixel commands and register writes through a queued driver. Every
// accepted pixel is run through an independent fixed-point escape-time and
// palette calculation. Each done word is checked field by field against the
// oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;
  import metp_pkg::*;

  localparam int     SETTLE      = 4;        // idle cycles before a register write
  localparam int     TAIL        = 40;
  localparam int     PHASES      = 8;
  localparam int     PHASE_ITEMS = 75;
  localparam longint RUN_LIMIT   = 3_000_000;
  localparam int     UNIT        = 1 << FRAC_BITS;   // 1.0 in Q4.28

  // Register values after reset
  localparam int unsigned DEF_LIMIT = 1000;
  localparam int          DEF_REAL  = -536870912;
  localparam int          DEF_IMAG  = -301989888;
  localparam int unsigned DEF_PITCH = 559241;

  localparam longint WORD_MAX  = 64'sd2147483647;
  localparam longint WORD_MIN  = -64'sd2147483648;
  localparam longint ESCAPE_SQ = longint'(4) <<< FRAC_BITS;

  // Palette: Q0.16 fraction, channel gains (blue 8.5 doubled, one more shift)
  localparam int QF      = 16;
  localparam int RED_K   = 9;
  localparam int GREEN_K = 15;
  localparam int BLUE_K  = 17;
  localparam int CH_MAX  = 255;

  typedef enum logic [1:0] {JOB_PIXEL, JOB_WRITE, JOB_DRAIN, JOB_PACE} job_kind_e;

  typedef struct packed {
    job_kind_e               kind;
    logic [COLUMN_BITS-1:0]  column;
    logic [ROW_BITS-1:0]     row;
    cfg_reg_e                reg_sel;
    logic [CFG_DATA_W-1:0]   data;
    logic [6:0]              gap_pct;
  } job_t;

  typedef struct packed {
    logic [ITER_W-1:0] count;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_color_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   start          = 1'b0;
  logic                   busy;
  logic [COLUMN_BITS-1:0] pixel_column_i = '0;
  logic [ROW_BITS-1:0]    pixel_row_i    = '0;
  logic                   cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i     = '0;
  logic                   done_o;
  logic [ITER_W-1:0]      iteration_count_o;
  logic [CHAN_W-1:0]      red_o;
  logic [CHAN_W-1:0]      green_o;
  logic [CHAN_W-1:0]      blue_o;

  job_t         job_q[$];
  pixel_color_t colors_due[$];

  // Predictor copy of the registers
  int unsigned limit_cfg    = DEF_LIMIT;
  int          real_org_cfg = DEF_REAL;
  int          imag_org_cfg = DEF_IMAG;
  int unsigned pitch_cfg    = DEF_PITCH;

  logic        took_word    = 1'b0;
  int unsigned gap_pct      = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches   = 0;
  int unsigned words_seen   = 0;
  longint      cycle_count  = 0;

  mandelbrot_escape_time_pixel DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .pixel_column_i    (pixel_column_i),
    .pixel_row_i       (pixel_row_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .done_o            (done_o),
    .iteration_count_o (iteration_count_o),
    .red_o             (red_o),
    .green_o           (green_o),
    .blue_o            (blue_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Escape-time and palette prediction
  // ---------------------------------------------------------------------------
  function automatic longint clamp_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // Q0.16 product, floored
  function automatic longint unsigned frac_mul(input longint unsigned a,
                                               input longint unsigned b);
    return (a * b) >> QF;
  endfunction

  function automatic logic [CHAN_W-1:0] tone(input longint unsigned k,
                                             input longint unsigned term,
                                             input int shift_by);
    longint unsigned v;
    v = (k * CH_MAX * term) >> shift_by;
    return (v > CH_MAX) ? CHAN_W'(CH_MAX) : v[CHAN_W-1:0];
  endfunction

  function automatic pixel_color_t escape_color(input logic [COLUMN_BITS-1:0] column,
                                                input logic [ROW_BITS-1:0] row);
    longint          cr, ci, zr, zi, rr, ii, ri;
    longint unsigned tq, uq, t2, t3, u2, u3;
    int unsigned     n;
    pixel_color_t    res;
    cr = clamp_word(longint'(real_org_cfg) + longint'(column) * longint'(pitch_cfg));
    ci = clamp_word(longint'(imag_org_cfg) + longint'(row) * longint'(pitch_cfg));
    zr = 0;
    zi = 0;
    n  = 0;
    // magnitude test comes before each iteration
    while (n < limit_cfg) begin
      rr = (zr * zr) >>> FRAC_BITS;
      ii = (zi * zi) >>> FRAC_BITS;
      if (rr + ii >= ESCAPE_SQ) break;
      ri = (zr * zi) >>> (FRAC_BITS - 1);
      zr = clamp_word(rr - ii + cr);
      zi = clamp_word(ri + ci);
      n++;
    end
    // t = count / limit in Q0.16, 1.0 clipped just below one
    tq = 0;
    if (limit_cfg != 0) tq = (64'(n) << QF) / 64'(limit_cfg);
    if (tq > (1 << QF) - 1) tq = (1 << QF) - 1;
    uq = (1 << QF) - tq;
    t2 = frac_mul(tq, tq);
    t3 = frac_mul(t2, tq);
    u2 = frac_mul(uq, uq);
    u3 = frac_mul(u2, uq);
    res.count = n[ITER_W-1:0];
    res.red   = tone(RED_K, frac_mul(t3, uq), QF);
    res.green = tone(GREEN_K, frac_mul(u2, t2), QF);
    res.blue  = tone(BLUE_K, frac_mul(u3, tq), QF + 1);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("ERROR %0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Job queue fill helpers
  // ---------------------------------------------------------------------------
  task automatic queue_pixel(input logic [COLUMN_BITS-1:0] column,
                             input logic [ROW_BITS-1:0] row);
    job_t j;
    j        = '0;
    j.kind   = JOB_PIXEL;
    j.column = column;
    j.row    = row;
    job_q.push_back(j);
  endtask

  task automatic queue_write(input cfg_reg_e sel, input logic [CFG_DATA_W-1:0] data);
    job_t j;
    j         = '0;
    j.kind    = JOB_WRITE;
    j.reg_sel = sel;
    j.data    = data;
    job_q.push_back(j);
  endtask

  task automatic queue_window(input logic [31:0] lim_word, input logic [31:0] re_word,
                              input logic [31:0] im_word, input logic [31:0] pitch_word);
    queue_write(REG_MAX_ITER, lim_word);
    queue_write(REG_REAL_ORIGIN, re_word);
    queue_write(REG_IMAG_ORIGIN, im_word);
    queue_write(REG_PIXEL_STEP, pitch_word);
  endtask

  task automatic queue_drain();
    job_t j;
    j      = '0;
    j.kind = JOB_DRAIN;
    job_q.push_back(j);
  endtask

  task automatic queue_pace(input int unsigned pct);
    job_t j;
    j         = '0;
    j.kind    = JOB_PACE;
    j.gap_pct = pct[6:0];
    job_q.push_back(j);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_cmds
    logic go;
    logic we;
    job_t head;
    go = start;
    we = 1'b0;
    if (rst_ni) begin
      if (colors_due.size() == 0 && !busy && !start) quiet_cycles++;
      else quiet_cycles = 0;
      // command taken at the last rising edge
      if (start && took_word) go = 1'b0;
      if (!go && job_q.size() != 0) begin
        head = job_q[0];
        case (head.kind)
          JOB_PIXEL: begin
            if ($urandom_range(0, 99) >= gap_pct) begin
              go = 1'b1;
              pixel_column_i <= head.column;
              pixel_row_i    <= head.row;
              job_q.delete(0);
            end
          end
          JOB_WRITE: begin
            // registers change only with the block idle
            if (quiet_cycles >= SETTLE) begin
              we = 1'b1;
              cfg_index_i <= head.reg_sel;
              cfg_data_i  <= head.data;
              job_q.delete(0);
            end
          end
          JOB_DRAIN: begin
            if (colors_due.size() == 0 && !busy) job_q.delete(0);
          end
          JOB_PACE: begin
            gap_pct = 32'(head.gap_pct);
            job_q.delete(0);
          end
          default: job_q.delete(0);
        endcase
      end
    end
    start    <= go;
    cfg_we_i <= we;
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples at the rising edge, predicts and checks
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_words
    pixel_color_t got;
    pixel_color_t want;
    if (!rst_ni) begin
      took_word    <= 1'b0;
      limit_cfg    = DEF_LIMIT;
      real_org_cfg = DEF_REAL;
      imag_org_cfg = DEF_IMAG;
      pitch_cfg    = DEF_PITCH;
    end else begin
      took_word <= start && !busy;
      // result word
      if (done_o) begin
        got = {iteration_count_o, red_o, green_o, blue_o};
        if (colors_due.size() == 0) begin
          report_mismatch($sformatf("result word %0d with no pixel pending", words_seen));
        end else begin
          want = colors_due.pop_front();
          if (got.count !== want.count)
            report_mismatch($sformatf("word %0d count %0d, expected %0d",
                                      words_seen, got.count, want.count));
          if (got.red !== want.red)
            report_mismatch($sformatf("word %0d red %0d, expected %0d",
                                      words_seen, got.red, want.red));
          if (got.green !== want.green)
            report_mismatch($sformatf("word %0d green %0d, expected %0d",
                                      words_seen, got.green, want.green));
          if (got.blue !== want.blue)
            report_mismatch($sformatf("word %0d blue %0d, expected %0d",
                                      words_seen, got.blue, want.blue));
        end
        words_seen++;
      end
      // register write
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MAX_ITER:    limit_cfg    = 32'(cfg_data_i[ITER_W-1:0]);
          REG_REAL_ORIGIN: real_org_cfg = cfg_data_i;
          REG_IMAG_ORIGIN: imag_org_cfg = cfg_data_i;
          REG_PIXEL_STEP:  pitch_cfg    = 32'(cfg_data_i[STEP_W-1:0]);
          default: ;
        endcase
      end
      // accepted command
      if (start && !busy) colors_due.push_back(escape_color(pixel_column_i, pixel_row_i));
    end
  end

  // Run limit
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels pending", cycle_count, colors_due.size());
      $display("** mandelbrot_escape_time_pixel: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned lim;
    int unsigned pitch;
    int unsigned junk;
    int          re0;
    int          im0;

    // reset window: corners, and the pixel that lands closest to c = 0
    queue_pixel(0, 0);
    queue_pixel(12'hFFF, 12'hFFF);
    queue_pixel(12'hFFF, 0);
    queue_pixel(0, 12'hFFF);
    queue_pixel(960, 540);
    // zero limit: no iteration, black
    queue_window(32'h0, 0, 0, 0);
    queue_pixel(100, 200);
    // limit of one inside the set: t clips, all channels zero
    queue_window(32'h1, 0, 0, 0);
    queue_pixel(12'hABC, 12'h543);
    // largest limit: one pixel runs the full count
    queue_window(32'hFFFF, 0, 0, 0);
    queue_pixel(12'h5A5, 12'hA5A);
    // coordinates past the word range saturate, escape after one iteration
    queue_window(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_pixel(12'hFFF, 12'hFFF);
    queue_pixel(1, 1);
    // most negative origin with zero pitch
    queue_window(32'h7, 32'h8000_0000, 32'h8000_0000, 0);
    queue_pixel(12'h3C3, 12'hC3C);
    // short limit over the region around the set
    queue_window(32'd20, -2 * UNIT, -UNIT, 196608);
    queue_pixel(2048, 1365);
    queue_pixel(2730, 1365);
    queue_pixel(1365, 2048);
    queue_pixel(2500, 700);
    queue_pixel(3000, 3000);

    // random phases: new window and pace each time
    for (int p = 0; p < PHASES; p++) begin
      queue_pace((p % 4 == 1) ? 45 : (p % 4 == 3) ? 16 : 0);
      if (p == 0) lim = 1;
      else if (p == PHASES - 1) lim = 255;
      else lim = $urandom_range(2, 200);
      if (p == 3 || p == 6) begin
        // any word at all, pitch bits above the register width too
        re0   = $urandom;
        im0   = $urandom;
        pitch = $urandom;
      end else begin
        re0   = -5 * UNIT / 2 + int'($urandom_range(0, UNIT));
        im0   = -3 * UNIT / 2 + int'($urandom_range(0, UNIT / 2));
        pitch = $urandom_range(40000, 220000);
      end
      junk = $urandom;
      queue_window({junk[31:16], lim[15:0]}, re0, im0, pitch);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) queue_drain();
        queue_pixel(COLUMN_BITS'($urandom_range(0, 4095)),
                    ROW_BITS'($urandom_range(0, 4095)));
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (job_q.size() != 0) @(posedge clk_i);
    while (colors_due.size() != 0 || busy || start) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** mandelbrot_escape_time_pixel: PASSED **");
    end else begin
      $display("** mandelbrot_escape_time_pixel: FAILED **");
    end
    $finish;
  end

endmodule

// ===== mandelbrot_escape_time_pixel.f =====
+incdir+hdl
hdl/metp_pkg.sv
hdl/mandelbrot_escape_time_pixel.sv
hdl/metp_checker.sv
verif/tb.sv
